// ----- sv/gsalu_pkg.sv -----
// types and constants shared by the scalar alu block and its checker
package gsalu_pkg;

  // instruction codes
  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_ADDC     = 4'd1,
    OP_SUB      = 4'd2,
    OP_SUBREV   = 4'd3,
    OP_SUBB     = 4'd4,
    OP_SUBBREV  = 4'd5,
    OP_ABSDIFF  = 4'd6,
    OP_ADDI     = 4'd7,
    OP_SUBI     = 4'd8,
    OP_SHLADD   = 4'd9,
    OP_MIN_S    = 4'd10,
    OP_MIN_U    = 4'd11,
    OP_MAX_S    = 4'd12,
    OP_MAX_U    = 4'd13,
    OP_CSELECT  = 4'd14,
    OP_SAVEEXEC = 4'd15
  } alu_op_t;

  // saveexec combine codes, the spare code acts as and
  localparam logic [1:0] LOGIC_AND   = 2'd0;
  localparam logic [1:0] LOGIC_OR    = 2'd1;
  localparam logic [1:0] LOGIC_XOR   = 2'd2;
  localparam logic [1:0] LOGIC_SPARE = 2'd3;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [63:0] EXEC_RESET = {64{1'b1}};

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] src_a;
    logic [31:0] src_a_high;
    logic [31:0] src_b;
    logic        vector_mode;
    logic        lane_carry_in;
    logic [4:0]  shift_amount;
    logic [1:0]  logic_op;
    logic        negate_exec;
    logic        negate_source;
    logic        wide;
  } req_t;

  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        cond_out;
    logic        lane_carry_out;
    logic [63:0] exec_out;
  } rsp_t;

endpackage

// ----- sv/gpu_scalar_alu_with_exec_mask_top.sv -----
// scalar alu with condition bit and 64-lane exec mask, input and result registers
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid, req_stall | req_t: op, sources, flags
//  rsp     | out       | rsp_valid, rsp_stall | rsp_t: result, cond, carry, exec
//
// one item per cycle unless rsp_stall holds; items pass the input then the result register
// the single alu pass between the input register and the result register sets the rate
// condition bit and exec mask update as an item moves into the result register,
// so the next item always sees them in time
// rst (synchronous) clears both valids, zeroes the condition bit and sets all exec lanes
// req_stall rises only when the input register is full and the result waits under rsp_stall
module gpu_scalar_alu_with_exec_mask_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  gsalu_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output gsalu_pkg::rsp_t rsp
);
  import gsalu_pkg::*;

  // input register
  logic        s1_valid;
  req_t        s1;

  // architectural state
  logic        cond_bit;
  logic [63:0] exec_mask;

  // alu outputs
  logic        s2_take;
  logic        cin;
  logic        rev;
  logic        bin;
  logic [31:0] lhs;
  logic [31:0] rhs;
  logic [32:0] sum33;
  logic [32:0] dif33;
  logic [31:0] diff;
  logic [31:0] addv;
  logic [31:0] elo;
  logic [31:0] ehi;
  logic [31:0] slo;
  logic [31:0] shi;
  logic [31:0] nlo;
  logic [31:0] nhi;
  logic        cout;
  logic        carry_op;
  logic [31:0] res_lo;
  logic [31:0] res_hi;
  logic        cond_next;
  logic        lane_out;
  logic [63:0] exec_next;

  // the result register frees up when empty or being drained this cycle
  assign s2_take   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s2_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
  end

  always_comb begin
    // carry or borrow in comes from the lane bit in vector mode
    cin   = s1.vector_mode ? s1.lane_carry_in : cond_bit;
    sum33 = {1'b0, s1.src_a} + {1'b0, s1.src_b}
          + {32'd0, (s1.op == OP_ADDC) ? cin : 1'b0};
    rev   = (s1.op == OP_SUBREV) || (s1.op == OP_SUBBREV);
    lhs   = rev ? s1.src_b : s1.src_a;
    rhs   = rev ? s1.src_a : s1.src_b;
    bin   = ((s1.op == OP_SUBB) || (s1.op == OP_SUBBREV)) ? cin : 1'b0;
    // bit 32 of the widened difference is the borrow out
    dif33 = {1'b0, lhs} - {1'b0, rhs} - {32'd0, bin};
    diff  = s1.src_a - s1.src_b;
    addv  = s1.src_a + s1.src_b;

    elo = s1.negate_exec ? ~exec_mask[31:0] : exec_mask[31:0];
    ehi = s1.negate_exec ? ~exec_mask[63:32] : exec_mask[63:32];
    slo = s1.negate_source ? ~s1.src_a : s1.src_a;
    shi = s1.negate_source ? ~s1.src_a_high : s1.src_a_high;
    priority case (s1.logic_op)
      LOGIC_OR: begin
        nlo = elo | slo;
        nhi = ehi | shi;
      end
      LOGIC_XOR: begin
        nlo = elo ^ slo;
        nhi = ehi ^ shi;
      end
      default: begin
        nlo = elo & slo;
        nhi = ehi & shi;
      end
    endcase

    res_lo    = 32'd0;
    res_hi    = 32'd0;
    cond_next = cond_bit;
    lane_out  = 1'b0;
    exec_next = exec_mask;
    carry_op  = 1'b0;
    cout      = 1'b0;

    unique case (s1.op)
      OP_ADD, OP_ADDC: begin
        res_lo   = sum33[31:0];
        cout     = sum33[32];
        carry_op = 1'b1;
      end
      OP_SUB, OP_SUBREV, OP_SUBB, OP_SUBBREV: begin
        res_lo   = dif33[31:0];
        cout     = dif33[32];
        carry_op = 1'b1;
      end
      OP_ABSDIFF: begin
        // most negative difference wraps back to itself
        res_lo    = diff[31] ? (32'd0 - diff) : diff;
        cond_next = (res_lo != 32'd0);
      end
      OP_ADDI: begin
        res_lo    = addv;
        cond_next = (((s1.src_a ^ addv) & (s1.src_b ^ addv) & SIGN_BIT) != 32'd0);
      end
      OP_SUBI: begin
        res_lo    = diff;
        cond_next = (((s1.src_a ^ s1.src_b) & (s1.src_a ^ diff) & SIGN_BIT) != 32'd0);
      end
      OP_SHLADD: begin
        res_lo = (s1.src_a << s1.shift_amount) + s1.src_b;
      end
      OP_MIN_S: begin
        cond_next = ($signed(s1.src_a) < $signed(s1.src_b));
        res_lo    = cond_next ? s1.src_a : s1.src_b;
      end
      OP_MAX_S: begin
        cond_next = ($signed(s1.src_a) > $signed(s1.src_b));
        res_lo    = cond_next ? s1.src_a : s1.src_b;
      end
      OP_MIN_U: begin
        cond_next = (s1.src_a < s1.src_b);
        res_lo    = cond_next ? s1.src_a : s1.src_b;
      end
      OP_MAX_U: begin
        cond_next = (s1.src_a > s1.src_b);
        res_lo    = cond_next ? s1.src_a : s1.src_b;
      end
      OP_CSELECT: begin
        res_lo = cond_bit ? s1.src_a : s1.src_b;
      end
      OP_SAVEEXEC: begin
        // old exec goes out, narrow form keeps the high word untouched
        res_lo = exec_mask[31:0];
        if (s1.wide) begin
          res_hi    = exec_mask[63:32];
          exec_next = {nhi, nlo};
          cond_next = ((nlo | nhi) != 32'd0);
        end else begin
          exec_next = {exec_mask[63:32], nlo};
          cond_next = (nlo != 32'd0);
        end
      end
    endcase

    if (carry_op) begin
      if (s1.vector_mode) begin
        lane_out = cout;
      end else begin
        cond_next = cout;
      end
    end
  end

  // state commits as the item enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cond_bit  <= 1'b0;
      exec_mask <= EXEC_RESET;
    end else if (s1_valid && s2_take) begin
      cond_bit  <= cond_next;
      exec_mask <= exec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_take) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_take) begin
      rsp.result_low     <= res_lo;
      rsp.result_high    <= res_hi;
      rsp.cond_out       <= cond_next;
      rsp.lane_carry_out <= lane_out;
      rsp.exec_out       <= exec_next;
    end
  end

endmodule

// ----- sv/gsalu_checker.sv -----
// port-level checker for the scalar alu, bound to the top level
module gsalu_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input gsalu_pkg::rsp_t rsp
);
  import gsalu_pkg::*;

  // exec mask as last delivered, the old exec seen by the next item
  logic [63:0] last_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_exec <= EXEC_RESET;
    end else if (rsp_valid && !rsp_stall) begin
      last_exec <= rsp.exec_out;
    end
  end

  // reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("block not empty after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled with result side free");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled item changed or dropped");

  // a nonzero high result only comes from wide saveexec, which returns old exec high
  a_old_exec: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.result_high != 32'd0) |-> rsp.result_high == last_exec[63:32])
    else $error("saveexec returned wrong old exec");

endmodule

bind gpu_scalar_alu_with_exec_mask_top gsalu_checker u_gsalu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- sim/gpu_scalar_alu_with_exec_mask_top_tb.sv -----
// self-checking testbench for the scalar alu with condition bit and exec mask
module gpu_scalar_alu_with_exec_mask_top_tb;
  import gsalu_pkg::*;

  // directed stimulus row, the result is typed in only where it is obvious
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t result;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // predictor state, mirrors the condition bit and the lane exec mask
  logic        model_cond;
  logic [63:0] model_exec;

  rsp_t     pending_results[$];
  dir_row_t dir_rows[$];
  rsp_t     want;
  int       mismatch_count = 0;
  bit       quiet = 1'b0;

  gpu_scalar_alu_with_exec_mask_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one, none at all in quiet phases
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // operand biased towards the corners of the 32-bit range
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return SIGN_BIT;
      3: return 32'h7FFF_FFFF;
      4: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t mk_req(alu_op_t op, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] ah = '0, logic vec = 1'b0,
                                  logic cin = 1'b0, logic [4:0] sh = '0,
                                  logic [1:0] lop = LOGIC_AND, logic ne = 1'b0,
                                  logic ns = 1'b0, logic w = 1'b0);
    req_t r;
    r.op = op;
    r.src_a = a;
    r.src_a_high = ah;
    r.src_b = b;
    r.vector_mode = vec;
    r.lane_carry_in = cin;
    r.shift_amount = sh;
    r.logic_op = lop;
    r.negate_exec = ne;
    r.negate_source = ns;
    r.wide = w;
    return r;
  endfunction

  // saveexec combine, the spare code falls back to and
  function automatic logic [31:0] exec_combine(logic [31:0] x, logic [31:0] y,
                                               logic [1:0] lop);
    case (lop)
      LOGIC_OR:  return x | y;
      LOGIC_XOR: return x ^ y;
      default:   return x & y;
    endcase
  endfunction

  // works out the result of one instruction and moves the predictor state on
  function automatic rsp_t alu_predict(req_t r);
    rsp_t        o;
    logic [32:0] sum;
    logic [31:0] lhs, rhs, borrow_in, part, diff, chk;
    logic [31:0] old_lo, old_hi, elo, ehi, slo, shi, nlo, nhi;
    logic        chain_in, carry_op, cout, less;
    o = '0;
    carry_op = 1'b0;
    cout = 1'b0;
    chain_in = r.vector_mode ? r.lane_carry_in : model_cond;
    case (r.op)
      OP_ADD, OP_ADDC: begin
        sum = {1'b0, r.src_a} + {1'b0, r.src_b} +
              33'((r.op == OP_ADDC) ? chain_in : 1'b0);
        o.result_low = sum[31:0];
        cout = sum[32];
        carry_op = 1'b1;
      end
      OP_SUB, OP_SUBREV, OP_SUBB, OP_SUBBREV: begin
        if (r.op == OP_SUBREV || r.op == OP_SUBBREV) begin
          lhs = r.src_b;
          rhs = r.src_a;
        end else begin
          lhs = r.src_a;
          rhs = r.src_b;
        end
        borrow_in = 32'((r.op == OP_SUBB || r.op == OP_SUBBREV) ? chain_in : 1'b0);
        part = lhs - rhs;
        cout = (lhs < rhs) || (part < borrow_in);
        o.result_low = part - borrow_in;
        carry_op = 1'b1;
      end
      OP_ABSDIFF: begin
        diff = r.src_a - r.src_b;
        o.result_low = diff[31] ? (32'h0 - diff) : diff;
        model_cond = (o.result_low != 32'h0);
      end
      OP_ADDI: begin
        o.result_low = r.src_a + r.src_b;
        chk = (r.src_a ^ o.result_low) & (r.src_b ^ o.result_low);
        model_cond = chk[31];
      end
      OP_SUBI: begin
        o.result_low = r.src_a - r.src_b;
        chk = (r.src_a ^ r.src_b) & (r.src_a ^ o.result_low);
        model_cond = chk[31];
      end
      OP_SHLADD: o.result_low = (r.src_a << r.shift_amount) + r.src_b;
      OP_MIN_S, OP_MAX_S: begin
        less = (r.op == OP_MIN_S) ? ($signed(r.src_a) < $signed(r.src_b))
                                  : ($signed(r.src_a) > $signed(r.src_b));
        o.result_low = less ? r.src_a : r.src_b;
        model_cond = less;
      end
      OP_MIN_U, OP_MAX_U: begin
        less = (r.op == OP_MIN_U) ? (r.src_a < r.src_b) : (r.src_a > r.src_b);
        o.result_low = less ? r.src_a : r.src_b;
        model_cond = less;
      end
      OP_CSELECT: o.result_low = model_cond ? r.src_a : r.src_b;
      default: begin
        old_lo = model_exec[31:0];
        old_hi = model_exec[63:32];
        elo = r.negate_exec ? ~old_lo : old_lo;
        ehi = r.negate_exec ? ~old_hi : old_hi;
        slo = r.negate_source ? ~r.src_a : r.src_a;
        shi = r.negate_source ? ~r.src_a_high : r.src_a_high;
        nlo = exec_combine(elo, slo, r.logic_op);
        o.result_low = old_lo;
        if (r.wide) begin
          nhi = exec_combine(ehi, shi, r.logic_op);
          o.result_high = old_hi;
          model_exec = {nhi, nlo};
          model_cond = ((nlo | nhi) != 32'h0);
        end else begin
          model_exec = {old_hi, nlo};
          model_cond = (nlo != 32'h0);
        end
      end
    endcase
    if (carry_op) begin
      if (r.vector_mode) o.lane_carry_out = cout;
      else model_cond = cout;
    end
    o.cond_out = model_cond;
    o.exec_out = model_exec;
    return o;
  endfunction

  function automatic void add_row(req_t r, bit typed = 1'b0, rsp_t res = '0);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.result = res;
    dir_rows.push_back(row);
  endfunction

  // one item onto the request channel, held until taken
  task automatic send_item(req_t r, bit typed, rsp_t typed_result);
    int   gap;
    rsp_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    // the predictor runs in order of issue, the typed value stands in where given
    predicted = alu_predict(r);
    pending_results.push_back(typed ? typed_result : predicted);
    do @(posedge clk); while (req_stall);
  endtask

  function automatic void check_field(string field, logic [63:0] want_v,
                                      logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // result side: random stall stretches, released during quiet phases
  initial begin : rsp_side
    int hold;
    hold = 0;
    rsp_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        hold--;
      end else begin
        rsp_stall <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // every taken result is compared against the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, got %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_low", 64'(want.result_low), 64'(rsp.result_low));
        check_field("result_high", 64'(want.result_high), 64'(rsp.result_high));
        check_field("cond_out", 64'(want.cond_out), 64'(rsp.cond_out));
        check_field("lane_carry_out", 64'(want.lane_carry_out), 64'(rsp.lane_carry_out));
        check_field("exec_out", want.exec_out, rsp.exec_out);
      end
    end
  end

  initial begin : req_side
    req_t r;
    int   n;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    model_cond = 1'b0;
    model_exec = EXEC_RESET;

    // carry out of an add lands in the condition bit and feeds the next add with carry
    add_row(mk_req(OP_ADD, 32'hFFFF_FFFF, 32'h1), 1'b1,
            '{32'h0, 32'h0, 1'b1, 1'b0, EXEC_RESET});
    add_row(mk_req(OP_ADDC, 32'hFFFF_FFFF, 32'h0), 1'b1,
            '{32'h0, 32'h0, 1'b1, 1'b0, EXEC_RESET});
    // vector mode, carry through the lane bit, condition untouched
    add_row(mk_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b1));
    add_row(mk_req(OP_ADDC, 32'h7FFF_FFFF, 32'h0, '0, 1'b1, 1'b1));
    add_row(mk_req(OP_SUB, 32'h0, 32'h1), 1'b1,
            '{32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, EXEC_RESET});
    add_row(mk_req(OP_SUBREV, 32'h5, 32'h3));
    add_row(mk_req(OP_SUBB, 32'h0, 32'h0));
    add_row(mk_req(OP_SUBBREV, 32'h0, 32'h0, '0, 1'b1, 1'b1));
    add_row(mk_req(OP_SUBB, 32'hFFFF_FFFF, 32'h0, '0, 1'b1, 1'b0));
    // absolute difference of the most negative value wraps back onto itself
    add_row(mk_req(OP_ABSDIFF, SIGN_BIT, 32'h0), 1'b1,
            '{SIGN_BIT, 32'h0, 1'b1, 1'b0, EXEC_RESET});
    add_row(mk_req(OP_ABSDIFF, 32'h3, 32'h3), 1'b1,
            '{32'h0, 32'h0, 1'b0, 1'b0, EXEC_RESET});
    // signed overflow both ways, vector mode has no effect here
    add_row(mk_req(OP_ADDI, 32'h7FFF_FFFF, 32'h1, '0, 1'b1, 1'b1));
    add_row(mk_req(OP_SUBI, SIGN_BIT, 32'h1));
    add_row(mk_req(OP_SHLADD, 32'hFFFF_FFFF, 32'h1, '0, 1'b0, 1'b0, 5'd31));
    add_row(mk_req(OP_MIN_S, SIGN_BIT, 32'h7FFF_FFFF));
    add_row(mk_req(OP_MIN_U, SIGN_BIT, 32'h7FFF_FFFF));
    add_row(mk_req(OP_MAX_S, SIGN_BIT, 32'h7FFF_FFFF));
    add_row(mk_req(OP_MAX_U, 32'hFFFF_FFFF, 32'h0, '0, 1'b1));
    add_row(mk_req(OP_CSELECT, 32'hAAAA_5555, 32'h5555_AAAA));
    // wide and with zero clears every lane and hands back the old mask
    add_row(mk_req(OP_SAVEEXEC, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '0, LOGIC_AND,
                   1'b0, 1'b0, 1'b1), 1'b1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0});
    // narrow saveexec touches only the low word
    add_row(mk_req(OP_SAVEEXEC, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0,
                   LOGIC_OR, 1'b1, 1'b1, 1'b0));
    // spare combine code behaves as and
    add_row(mk_req(OP_SAVEEXEC, 32'hF0F0_F0F0, 32'h0, 32'h1234_5678, 1'b1, 1'b1,
                   '0, LOGIC_SPARE, 1'b1, 1'b0, 1'b1));
    add_row(mk_req(OP_SAVEEXEC, 32'h0000_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0,
                   '0, LOGIC_XOR, 1'b0, 1'b1, 1'b1));
    add_row(mk_req(OP_SAVEEXEC, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '0, LOGIC_XOR,
                   1'b1, 1'b0, 1'b0));
    add_row(mk_req(OP_CSELECT, 32'h1, 32'h2));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // typed rows carry their own result
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].result);

    for (n = 0; n < 600; n++) begin
      // a stretch of back-to-back traffic in every third block of a hundred
      quiet = ((n / 100) % 3 == 1);
      r.op = alu_op_t'($urandom_range(0, 15));
      r.src_a = rand_word();
      r.src_a_high = rand_word();
      r.src_b = ($urandom_range(0, 7) == 0) ? r.src_a : rand_word();
      r.vector_mode = 1'($urandom_range(0, 1));
      r.lane_carry_in = 1'($urandom_range(0, 1));
      r.shift_amount = 5'($urandom_range(0, 31));
      r.logic_op = 2'($urandom_range(0, 3));
      r.negate_exec = 1'($urandom_range(0, 1));
      r.negate_source = 1'($urandom_range(0, 1));
      r.wide = 1'($urandom_range(0, 1));
      send_item(r, 1'b0, '0);
    end
    quiet = 1'b0;
    @(negedge clk);
    req_valid <= 1'b0;

    // drain, then keep watching for anything stray to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
